FILE: sv/cbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_pkg: shared types and constants of the clamped box blur core
// Field widths, command and status structs, and the codes used by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package cbb_pkg;

  // Default geometry limits.
  localparam int DefMaxWidth  = 64;
  localparam int DefMaxHeight = 64;
  localparam int DefMaxRadius = 63;

  // Reset value of the width and height registers before clamping.
  localparam int DimReset = 64;

  // Field and register widths.
  localparam int RadiusW    = 6;
  localparam int DimW       = 7;
  localparam int CoordW     = 7;
  localparam int ReadCoordW = 6;
  localparam int ByteW      = 8;
  localparam int StatusW    = 2;
  localparam int RowSumW    = 14;
  localparam int SumW       = 20;
  localparam int SpanW      = 7;
  localparam int AreaW      = 14;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 7;

  // The divider retires two quotient bits per step.
  localparam int DivSteps = SumW / 2;
  localparam int CntW     = $clog2(DivSteps);

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_OUTSIDE    = 2'd1,
    ST_NOT_LOADED = 2'd2
  } status_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_t;

  // Corners of the window in the summed-area table, in fetch order.
  typedef enum logic [1:0] {
    CORNER_D = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2,
    CORNER_A = 2'd3
  } corner_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_accept;
    logic    read_accept;
    logic    load_fetch;
    logic    load_write;
    logic    fetch;
    corner_t corner;
    logic    divide;
    logic    report;
  } cbb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic read_ok;
    logic loaded;
  } cbb_stat_t;

endpackage
`default_nettype wire

FILE: sv/cbb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cbb_ram #(
  parameter int WIDTH = cbb_pkg::SumW,
  parameter int DEPTH = cbb_pkg::DefMaxWidth * cbb_pkg::DefMaxHeight,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/cbb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_datapath: registers, summed-area table and divider of the blur core
// Holds the configuration and load position, builds the table entries,
// fetches the four window corners and divides the window sum by its area.
// ----------------------------------------------------------------------------
module cbb_datapath #(
  parameter int MAX_WIDTH  = cbb_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = cbb_pkg::DefMaxHeight,
  parameter int MAX_RADIUS = cbb_pkg::DefMaxRadius
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cbb_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [cbb_pkg::CfgDataW-1:0]    cfg_data,
  input  logic [cbb_pkg::ByteW-1:0]       mask_byte,
  input  logic [cbb_pkg::ReadCoordW-1:0]  read_column,
  input  logic [cbb_pkg::ReadCoordW-1:0]  read_row,
  input  cbb_pkg::cbb_cmd_t               cmd,
  output cbb_pkg::cbb_stat_t              stat,
  output logic                            done,
  output logic [cbb_pkg::ByteW-1:0]       blurred_value,
  output logic [cbb_pkg::StatusW-1:0]     status
);

  import cbb_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [DimW-1:0] WidthReset  =
      DimW'((MAX_WIDTH < DimReset) ? MAX_WIDTH : DimReset);
  localparam logic [DimW-1:0] HeightReset =
      DimW'((MAX_HEIGHT < DimReset) ? MAX_HEIGHT : DimReset);

  // Table address of a pixel.
  function automatic logic [AddrW-1:0] addr_of(input logic [CoordW-1:0] x,
                                               input logic [CoordW-1:0] y);
    return AddrW'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

  // A dimension of zero counts as one; larger than the limit counts as the limit.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input int cap);
    if (v == '0) begin
      return DimW'(1);
    end
    if (int'(v) > cap) begin
      return DimW'(cap);
    end
    return v;
  endfunction

  // Configuration registers.
  logic [RadiusW-1:0] radius;
  logic [DimW-1:0]    img_width;
  logic [DimW-1:0]    img_height;
  logic [RadiusW-1:0] radius_value;
  logic               restart;

  // Load position and running row sum.
  logic [CoordW-1:0]  load_column;
  logic [CoordW-1:0]  load_row;
  logic [RowSumW-1:0] row_sum;
  logic               image_loaded;
  logic [CoordW-1:0]  col_inc;
  logic [CoordW-1:0]  row_inc;
  logic               wrap_col;
  logic               wrap_row;
  logic [CoordW-1:0]  ld_x;
  logic [CoordW-1:0]  ld_y;
  logic [CoordW-1:0]  ld_y_m1;

  // Read window.
  logic [CoordW-1:0]  cx;
  logic [CoordW-1:0]  cy;
  logic [CoordW-1:0]  r_ext;
  logic [CoordW-1:0]  x_hi;
  logic [CoordW-1:0]  y_hi;
  logic [CoordW-1:0]  w_m1;
  logic [CoordW-1:0]  h_m1;
  logic [CoordW-1:0]  win_xa;
  logic [CoordW-1:0]  win_xb;
  logic [CoordW-1:0]  win_ya;
  logic [CoordW-1:0]  win_yb;
  logic [CoordW-1:0]  xa_m1;
  logic [CoordW-1:0]  ya_m1;
  logic               in_image;
  status_t            read_code;
  status_t            read_code_next;

  // Corner fetch and accumulation.
  logic [CoordW-1:0]  corner_x;
  logic [CoordW-1:0]  corner_y;
  logic               corner_use;
  logic               corner_neg;
  logic               acc_en_d;
  logic               acc_use_d;
  logic               acc_neg_d;
  logic [SumW-1:0]    acc;
  logic [SumW-1:0]    acc_term;

  // Divider.
  logic [SpanW-1:0]   span_x;
  logic [SpanW-1:0]   span_y;
  logic [AreaW-1:0]   area;
  logic [AreaW-1:0]   rem;
  logic [AreaW:0]     div_s1;
  logic [AreaW:0]     div_s2;
  logic               div_q1;
  logic               div_q2;
  logic [AreaW-1:0]   div_r1;
  logic [AreaW-1:0]   div_r2;

  // Table ports.
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [SumW-1:0]    ram_wdata;
  logic [AddrW-1:0]   ram_raddr;
  logic [SumW-1:0]    ram_rdata;

  // Configuration writes. A change of geometry restarts loading.
  assign radius_value = (int'(cfg_data[RadiusW-1:0]) > MAX_RADIUS) ?
                        RadiusW'(MAX_RADIUS) : cfg_data[RadiusW-1:0];
  assign restart = cfg_write &&
                   (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= '0;
      img_width  <= WidthReset;
      img_height <= HeightReset;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RADIUS: radius     <= radius_value;
        CFG_WIDTH:  img_width  <= clamp_dim(cfg_data, MAX_WIDTH);
        CFG_HEIGHT: img_height <= clamp_dim(cfg_data, MAX_HEIGHT);
        default: begin
        end
      endcase
    end
  end

  // Raster position advance for a load beat.
  assign col_inc  = load_column + CoordW'(1);
  assign row_inc  = load_row + CoordW'(1);
  assign wrap_col = (col_inc >= img_width);
  assign wrap_row = (row_inc >= img_height);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      load_column  <= '0;
      load_row     <= '0;
      row_sum      <= '0;
      image_loaded <= 1'b0;
    end else if (cmd.load_accept) begin
      load_column <= wrap_col ? '0 : col_inc;
      if (wrap_col) begin
        load_row <= wrap_row ? '0 : row_inc;
        if (wrap_row) begin
          image_loaded <= 1'b1;
        end
      end
      row_sum <= (load_column == '0) ? RowSumW'(mask_byte) :
                 row_sum + RowSumW'(mask_byte);
    end
  end

  // Pixel being loaded, kept for the read-above and write cycles.
  always_ff @(posedge clk) begin
    if (cmd.load_accept) begin
      ld_x <= load_column;
      ld_y <= load_row;
    end
  end

  assign ld_y_m1 = ld_y - CoordW'(1);

  // Window bounds clipped to the image, worked out as the read beat arrives.
  assign cx       = CoordW'(read_column);
  assign cy       = CoordW'(read_row);
  assign r_ext    = CoordW'(radius);
  assign x_hi     = cx + r_ext;
  assign y_hi     = cy + r_ext;
  assign w_m1     = img_width - CoordW'(1);
  assign h_m1     = img_height - CoordW'(1);
  assign in_image = (cx < img_width) && (cy < img_height);

  always_comb begin
    if (!image_loaded) begin
      read_code_next = ST_NOT_LOADED;
    end else if (!in_image) begin
      read_code_next = ST_OUTSIDE;
    end else begin
      read_code_next = ST_OK;
    end
  end

  assign stat.read_ok = image_loaded && in_image;
  assign stat.loaded  = image_loaded;

  always_ff @(posedge clk) begin
    if (cmd.read_accept) begin
      win_xa    <= (cx > r_ext) ? cx - r_ext : '0;
      win_ya    <= (cy > r_ext) ? cy - r_ext : '0;
      win_xb    <= (x_hi > w_m1) ? w_m1 : x_hi;
      win_yb    <= (y_hi > h_m1) ? h_m1 : y_hi;
      read_code <= read_code_next;
    end
  end

  // Clipped area; the window is stable long before the divider needs it.
  assign span_x = win_xb - win_xa + SpanW'(1);
  assign span_y = win_yb - win_ya + SpanW'(1);

  always_ff @(posedge clk) begin
    area <= AreaW'(span_x) * AreaW'(span_y);
  end

  // Corner addressing: D and A add, B and C subtract; edges drop out.
  assign xa_m1 = win_xa - CoordW'(1);
  assign ya_m1 = win_ya - CoordW'(1);

  always_comb begin
    unique case (cmd.corner)
      CORNER_D: begin
        corner_x   = win_xb;
        corner_y   = win_yb;
        corner_use = 1'b1;
        corner_neg = 1'b0;
      end
      CORNER_B: begin
        corner_x   = win_xb;
        corner_y   = ya_m1;
        corner_use = (win_ya != '0);
        corner_neg = 1'b1;
      end
      CORNER_C: begin
        corner_x   = xa_m1;
        corner_y   = win_yb;
        corner_use = (win_xa != '0);
        corner_neg = 1'b1;
      end
      CORNER_A: begin
        corner_x   = xa_m1;
        corner_y   = ya_m1;
        corner_use = (win_xa != '0) && (win_ya != '0);
        corner_neg = 1'b0;
      end
    endcase
  end

  // Table access: above-neighbor reads and writes for loads, corners for reads.
  assign ram_raddr = cmd.load_fetch ? addr_of(ld_x, ld_y_m1) :
                                      addr_of(corner_x, corner_y);
  assign ram_we    = cmd.load_write;
  assign ram_waddr = addr_of(ld_x, ld_y);
  assign ram_wdata = ((ld_y != '0) ? ram_rdata : '0) + SumW'(row_sum);

  cbb_ram #(
    .WIDTH (SumW),
    .DEPTH (Depth)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Corner data arrives in the cycle after its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en_d <= 1'b0;
    end else begin
      acc_en_d <= cmd.fetch;
    end
  end

  always_ff @(posedge clk) begin
    acc_use_d <= corner_use;
    acc_neg_d <= corner_neg;
  end

  assign acc_term = acc_use_d ? ram_rdata : '0;

  // Restoring division, two quotient bits per step. The sum register shifts
  // out dividend bits and shifts in quotient bits.
  always_comb begin
    div_s1 = {rem, acc[SumW-1]};
    div_q1 = (div_s1 >= {1'b0, area});
    div_r1 = div_q1 ? AreaW'(div_s1 - {1'b0, area}) : div_s1[AreaW-1:0];
    div_s2 = {div_r1, acc[SumW-2]};
    div_q2 = (div_s2 >= {1'b0, area});
    div_r2 = div_q2 ? AreaW'(div_s2 - {1'b0, area}) : div_s2[AreaW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.read_accept) begin
      acc <= '0;
      rem <= '0;
    end else if (acc_en_d) begin
      acc <= acc_neg_d ? acc - acc_term : acc + acc_term;
    end else if (cmd.divide) begin
      acc <= {acc[SumW-3:0], div_q1, div_q2};
      rem <= div_r2;
    end
  end

  // Result registers; the strobe lasts one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      blurred_value <= (read_code == ST_OK) ? acc[ByteW-1:0] : '0;
      status        <= read_code;
    end
  end

endmodule
`default_nettype wire

FILE: sv/cbb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbb_ctrl: sequencer of the blur core
// Accepts beats and steps the datapath through table update, corner
// fetch, division and result report.
// ----------------------------------------------------------------------------
module cbb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cbb_pkg::kind_t     kind,
  input  cbb_pkg::cbb_stat_t stat,
  output cbb_pkg::cbb_cmd_t  cmd,
  output logic               busy
);

  import cbb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_LD_READ  = 7'b0000010,
    S_LD_WRITE = 7'b0000100,
    S_FETCH    = 7'b0001000,
    S_DRAIN    = 7'b0010000,
    S_DIVIDE   = 7'b0100000,
    S_REPORT   = 7'b1000000
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_next;

  assign busy = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.corner = corner_t'(cnt[1:0]);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_LOAD) begin
            cmd.load_accept = 1'b1;
            state_next      = S_LD_READ;
          end else begin
            cmd.read_accept = 1'b1;
            cnt_next        = '0;
            state_next      = stat.read_ok ? S_FETCH : S_REPORT;
          end
        end
      end
      S_LD_READ: begin
        cmd.load_fetch = 1'b1;
        state_next     = S_LD_WRITE;
      end
      S_LD_WRITE: begin
        cmd.load_write = 1'b1;
        state_next     = S_IDLE;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (corner_t'(cnt[1:0]) == CORNER_A) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + CntW'(1);
        end
      end
      S_DRAIN: begin
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.divide = 1'b1;
        if (cnt == CntW'(DivSteps - 1)) begin
          state_next = S_REPORT;
        end else begin
          cnt_next = cnt + CntW'(1);
        end
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/clamped_box_blur_integral_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clamped_box_blur_integral_core: box blur of a mask via a summed-area table
// A load beat reads the table entry above from the single read port, then
// writes the new entry. A read beat inside a loaded image makes four
// corner fetches through the one read port, then a drain step, ten steps
// of a two-bit-per-cycle divider and a report step. A read before a full
// image is loaded, or outside the image, goes straight to the report step.
// busy is high from the cycle after a beat is accepted until the
// block can take another; start is ignored while busy. Each result appears
// for exactly one cycle with done high and cannot be stalled. The table
// needs no clearing pass after reset. Configuration writes are meant for
// idle periods; a width or height write restarts loading at the origin.
// ----------------------------------------------------------------------------
module clamped_box_blur_integral_core #(
  parameter int MAX_WIDTH  = cbb_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = cbb_pkg::DefMaxHeight,
  parameter int MAX_RADIUS = cbb_pkg::DefMaxRadius
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind,
  input  logic [cbb_pkg::ByteW-1:0]       mask_byte,
  input  logic [cbb_pkg::ReadCoordW-1:0]  read_column,
  input  logic [cbb_pkg::ReadCoordW-1:0]  read_row,
  output logic                            done,
  output logic [cbb_pkg::ByteW-1:0]       blurred_value,
  output logic [cbb_pkg::StatusW-1:0]     status,
  input  logic                            cfg_write,
  input  logic [cbb_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [cbb_pkg::CfgDataW-1:0]    cfg_data
);

  import cbb_pkg::*;

  cbb_cmd_t  cmd;
  cbb_stat_t stat;

  // Sequencer.
  cbb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind_t'(kind)),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Table, window arithmetic and divider.
  cbb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mask_byte     (mask_byte),
    .read_column   (read_column),
    .read_row      (read_row),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .blurred_value (blurred_value),
    .status        (status)
  );

  // A result beat is never followed directly by another one.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe held for more than one cycle");

  // Every table write follows the read of the entry above.
  assert property (@(posedge clk) disable iff (rst)
                   cmd.load_write |-> $past(cmd.load_fetch))
    else $error("table write without preceding read-above");

  // A rejected read reports in the very next cycle.
  assert property (@(posedge clk) disable iff (rst)
                   (cmd.read_accept && !stat.read_ok) |=> cmd.report)
    else $error("rejected read did not report at once");

  // A result carries one of the defined status codes.
  assert property (@(posedge clk) disable iff (rst)
                   done |-> (status == ST_OK || status == ST_OUTSIDE ||
                             status == ST_NOT_LOADED))
    else $error("result with undefined status code");

endmodule
`default_nettype wire
